// ----- rtl/core/pps_pkg.sv -----
// Shared types, widths and codes of the preemptive priority scheduler.
package pps_pkg;

	localparam int unsigned MAX_PROCS_DEF = 8;

	localparam int unsigned SLOT_W  = 3;
	localparam int unsigned TIME_W  = 16;
	localparam int unsigned PRIO_W  = 8;
	localparam int unsigned DONE_W  = 4;
	localparam int unsigned CFG_W   = 4;

	localparam int unsigned S_TDATA_W = 48;
	localparam int unsigned S_TUSER_W = 1;
	localparam int unsigned M_TDATA_W = 56;
	localparam int unsigned M_TUSER_W = 2;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [DONE_W-1:0] DONE_MAX = '1;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FIN1,
		ST_FIN2
	} state_t;

	typedef struct packed {
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] burst;
		logic [PRIO_W-1:0] prio;
	} slot_rec_t;

	typedef struct packed {
		logic              en;
		logic              info_en;
		slot_rec_t         rec;
		logic [TIME_W-1:0] rem;
	} slot_wr_t;

endpackage

// ----- rtl/core/preemptive_priority_scheduler.sv -----
// Tick-driven preemptive priority scheduler over a small file of process slots.
// A load request (tuser 0) writes one slot and restarts time and the completion
// count. A tick request (tuser 1) walks the slots in use through the slot store,
// which has a single read port, one per cycle, keeping the ready slot with the
// smallest priority (lowest index on ties), then retires it by one unit and forms
// the result: s_tready stays low through the scan, drain and finish states until
// the tick returns to idle. The result sits in an output register and a new
// request may be taken while it waits; a tick waits at its last step while that
// register is full.
module preemptive_priority_scheduler #(
	parameter int unsigned MAX_PROCS = pps_pkg::MAX_PROCS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pps_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// slot[2:0], burst[18:3], arrival[34:19], priority_req[42:35], zero pad
	input  logic [pps_pkg::S_TDATA_W-1:0]   s_tdata,
	// cmd[0]
	input  logic [pps_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// slice_end_time[15:0], running_slot[18:16], turnaround[34:19], waiting[50:35],
	// all_done[51], zero pad
	output logic [pps_pkg::M_TDATA_W-1:0]   m_tdata,
	// idle[0], finished[1]
	output logic [pps_pkg::M_TUSER_W-1:0]   m_tuser
);

	localparam int unsigned IDX_W = $clog2(MAX_PROCS);
	localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);
	localparam int unsigned TW    = pps_pkg::TIME_W;

	pps_pkg::state_t                state_q, state_d;
	logic [pps_pkg::CFG_W-1:0]      proc_count_q;
	logic [CNT_W-1:0]               n_eff;
	logic [IDX_W-1:0]               scan_idx_q;
	logic                           scan_last;
	logic                           vld_s1;
	logic [IDX_W-1:0]               idx_s1;
	logic                           found_q;
	logic [IDX_W-1:0]               best_idx_q;
	pps_pkg::slot_rec_t             best_rec_q;
	logic [TW-1:0]                  best_rem_q;
	logic [TW-1:0]                  time_q;
	logic [pps_pkg::DONE_W-1:0]     done_q;
	logic                           fin_q;
	logic [TW-1:0]                  tat_q;
	logic                           m_tvalid_q;
	logic [pps_pkg::M_TDATA_W-1:0]  m_tdata_q;
	logic [pps_pkg::M_TUSER_W-1:0]  m_tuser_q;

	logic                           in_acc;
	logic                           in_cmd;
	logic [pps_pkg::SLOT_W-1:0]     in_slot;
	pps_pkg::slot_rec_t             in_rec;
	logic                           slot_ok;
	logic                           load_acc;
	logic                           tick_acc;
	pps_pkg::slot_wr_t              wr;
	logic [IDX_W-1:0]               wr_addr;
	pps_pkg::slot_rec_t             rd_rec_s1;
	logic [TW-1:0]                  rd_rem_s1;
	logic                           cand_ready;
	logic                           take;
	logic [TW-1:0]                  t_next;
	logic [TW-1:0]                  rem_dec;
	logic [TW-1:0]                  wt;
	logic                           out_free;
	logic                           out_load;
	logic                           all_done;

	assign cfg_ready = 1'b1;

	assign in_cmd      = s_tuser[0];
	assign in_slot     = s_tdata[2:0];
	assign in_rec.burst   = s_tdata[18:3];
	assign in_rec.arrival = s_tdata[34:19];
	assign in_rec.prio    = s_tdata[42:35];
	assign in_acc      = s_tvalid && s_tready;
	assign slot_ok     = 32'(in_slot) < MAX_PROCS;
	assign load_acc    = in_acc && (in_cmd == pps_pkg::CMD_LOAD) && slot_ok;
	assign tick_acc    = in_acc && (in_cmd == pps_pkg::CMD_TICK);

	always_comb begin
		if (proc_count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (32'(proc_count_q) > MAX_PROCS) begin
			n_eff = CNT_W'(MAX_PROCS);
		end else begin
			n_eff = CNT_W'(proc_count_q);
		end
	end

	assign scan_last  = (CNT_W'(scan_idx_q) + CNT_W'(1)) == n_eff;
	assign cand_ready = vld_s1 && (rd_rem_s1 != '0) && (rd_rec_s1.arrival <= time_q);
	assign take       = cand_ready && (!found_q || (rd_rec_s1.prio < best_rec_q.prio));
	assign t_next     = (time_q == pps_pkg::TIME_MAX) ? time_q : time_q + TW'(1);
	assign rem_dec    = best_rem_q - TW'(1);
	assign wt         = (tat_q >= best_rec_q.burst) ? tat_q - best_rec_q.burst : '0;
	assign all_done   = 32'(done_q) >= 32'(n_eff);
	assign out_free   = !m_tvalid_q || m_tready;

	pps_slot_store #(
		.MAX_PROCS (MAX_PROCS)
	) u_store (
		.clk       (clk),
		.wr        (wr),
		.wr_addr   (wr_addr),
		.rd_addr   (scan_idx_q),
		.rd_rec_s1 (rd_rec_s1),
		.rd_rem_s1 (rd_rem_s1)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			pps_pkg::ST_IDLE: begin
				if (tick_acc) begin
					state_d = pps_pkg::ST_SCAN;
				end
			end
			pps_pkg::ST_SCAN: begin
				if (scan_last) begin
					state_d = pps_pkg::ST_DRAIN;
				end
			end
			pps_pkg::ST_DRAIN: begin
				state_d = pps_pkg::ST_FIN1;
			end
			pps_pkg::ST_FIN1: begin
				state_d = pps_pkg::ST_FIN2;
			end
			pps_pkg::ST_FIN2: begin
				if (out_free) begin
					state_d = pps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pps_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready    = 1'b0;
		out_load    = 1'b0;
		wr.en       = 1'b0;
		wr.info_en  = 1'b0;
		wr.rec      = in_rec;
		wr.rem      = in_rec.burst;
		wr_addr     = IDX_W'(in_slot);
		case (state_q)
			pps_pkg::ST_IDLE: begin
				s_tready   = 1'b1;
				wr.en      = load_acc;
				wr.info_en = 1'b1;
			end
			pps_pkg::ST_FIN1: begin
				wr.en   = found_q;
				wr.rem  = rem_dec;
				wr_addr = best_idx_q;
			end
			pps_pkg::ST_FIN2: begin
				out_load = out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pps_pkg::ST_IDLE;
			proc_count_q <= pps_pkg::CFG_W'(1);
			scan_idx_q   <= '0;
			vld_s1       <= 1'b0;
			found_q      <= 1'b0;
			time_q       <= '0;
			done_q       <= '0;
			fin_q        <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == pps_pkg::ST_SCAN);
			if (cfg_valid && cfg_ready) begin
				proc_count_q <= cfg_data;
			end
			if (load_acc) begin
				time_q <= '0;
				done_q <= '0;
			end
			if (tick_acc) begin
				scan_idx_q <= '0;
				found_q    <= 1'b0;
			end else if (state_q == pps_pkg::ST_SCAN && !scan_last) begin
				scan_idx_q <= scan_idx_q + IDX_W'(1);
			end
			if (take) begin
				found_q <= 1'b1;
			end
			if (state_q == pps_pkg::ST_FIN1) begin
				time_q <= t_next;
				fin_q  <= found_q && (rem_dec == '0);
				if (found_q && (rem_dec == '0) && (done_q != pps_pkg::DONE_MAX)) begin
					done_q <= done_q + pps_pkg::DONE_W'(1);
				end
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_idx_q;
		if (take) begin
			best_idx_q <= idx_s1;
			best_rec_q <= rd_rec_s1;
			best_rem_q <= rd_rem_s1;
		end
		if (state_q == pps_pkg::ST_FIN1) begin
			tat_q <= t_next - best_rec_q.arrival;
		end
		if (out_load) begin
			m_tdata_q[15:0]  <= time_q;
			m_tdata_q[18:16] <= found_q ? pps_pkg::SLOT_W'(best_idx_q) : '0;
			m_tdata_q[34:19] <= fin_q ? tat_q : '0;
			m_tdata_q[50:35] <= fin_q ? wt : '0;
			m_tdata_q[51]    <= all_done;
			m_tdata_q[55:52] <= '0;
			m_tuser_q[0]     <= !found_q;
			m_tuser_q[1]     <= fin_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ----- rtl/core/pps_slot_store.sv -----
// Process slot store: slot records and remaining bursts, one write and one registered read port.
module pps_slot_store #(
	parameter int unsigned MAX_PROCS = pps_pkg::MAX_PROCS_DEF,
	localparam int unsigned IDX_W = $clog2(MAX_PROCS)
) (
	input  logic                          clk,
	input  pps_pkg::slot_wr_t             wr,
	input  logic [IDX_W-1:0]              wr_addr,
	input  logic [IDX_W-1:0]              rd_addr,
	output pps_pkg::slot_rec_t            rd_rec_s1,
	output logic [pps_pkg::TIME_W-1:0]    rd_rem_s1
);

	pps_pkg::slot_rec_t             rec_mem [MAX_PROCS];
	logic [pps_pkg::TIME_W-1:0]     rem_mem [MAX_PROCS];

	always_ff @(posedge clk) begin
		if (wr.en && wr.info_en) begin
			rec_mem[wr_addr] <= wr.rec;
		end
		if (wr.en) begin
			rem_mem[wr_addr] <= wr.rem;
		end
	end

	always_ff @(posedge clk) begin
		rd_rec_s1 <= rec_mem[rd_addr];
		rd_rem_s1 <= rem_mem[rd_addr];
	end

endmodule

// ----- rtl/core/pps_checker.sv -----
// Port-level checks of the preemptive priority scheduler and their binding.
module pps_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [pps_pkg::S_TUSER_W-1:0]   s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [pps_pkg::M_TDATA_W-1:0]   m_tdata,
	input logic [pps_pkg::M_TUSER_W-1:0]   m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[0] == pps_pkg::CMD_TICK) |=> !s_tready)
		else $error("request taken during a tick");

	a_idle_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata[18:16] == '0) && !m_tuser[1])
		else $error("idle slice names a slot or a finish");

	a_no_fin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> (m_tdata[50:19] == '0))
		else $error("times reported without a finish");

	a_wait_le_tat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[50:35] <= m_tdata[34:19]))
		else $error("waiting exceeds turnaround");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ----- tb/preemptive_priority_scheduler_tb.sv -----
// Self-checking testbench for the preemptive priority scheduler.
`timescale 1ns / 100ps

module preemptive_priority_scheduler_tb;

	localparam int NSLOTS       = pps_pkg::MAX_PROCS_DEF;
	localparam int RANDOM_ITEMS = 600;
	localparam int DRAIN_CYCLES = 24;

	typedef struct packed {
		logic [pps_pkg::TIME_W-1:0] end_time;
		logic [pps_pkg::SLOT_W-1:0] run_slot;
		logic                       idle;
		logic                       finished;
		logic [pps_pkg::TIME_W-1:0] turnaround;
		logic [pps_pkg::TIME_W-1:0] waiting;
		logic                       all_done;
	} slice_t;

	class sched_ledger;
		logic [pps_pkg::TIME_W-1:0] arr_t [NSLOTS];
		logic [pps_pkg::TIME_W-1:0] burst_t [NSLOTS];
		logic [pps_pkg::PRIO_W-1:0] prio_t [NSLOTS];
		logic [pps_pkg::TIME_W-1:0] left_t [NSLOTS];
		logic [pps_pkg::TIME_W-1:0] now;
		logic [pps_pkg::DONE_W-1:0] done_cnt;
		logic [pps_pkg::CFG_W-1:0]  proc_cnt;
		slice_t                     slices_due [$];
		int                         errors, ticks, loads, idles, finishes, all_done_seen, settings;

		function new();
			for (int i = 0; i < NSLOTS; i++) begin
				arr_t[i] = '0;
				burst_t[i] = '0;
				prio_t[i] = '0;
				left_t[i] = '0;
			end
			now = '0;
			done_cnt = '0;
			proc_cnt = pps_pkg::CFG_W'(1);
		endfunction

		function int in_use();
			if (proc_cnt == 0) return 1;
			if (proc_cnt > NSLOTS) return NSLOTS;
			return proc_cnt;
		endfunction

		function void set_proc_count(logic [pps_pkg::CFG_W-1:0] v);
			proc_cnt = v;
			settings++;
		endfunction

		function void take_request(logic cmd, logic [pps_pkg::SLOT_W-1:0] s,
				logic [pps_pkg::TIME_W-1:0] b, logic [pps_pkg::TIME_W-1:0] a,
				logic [pps_pkg::PRIO_W-1:0] p);
			int pick;
			int n;
			slice_t r;
			if (cmd == pps_pkg::CMD_LOAD) begin
				loads++;
				if (s < NSLOTS) begin
					burst_t[s] = b;
					arr_t[s] = a;
					prio_t[s] = p;
					left_t[s] = b;
					now = '0;
					done_cnt = '0;
				end
				return;
			end
			ticks++;
			n = in_use();
			pick = -1;
			for (int i = 0; i < n; i++) begin
				if (left_t[i] != 0 && arr_t[i] <= now) begin
					if (pick < 0 || prio_t[i] < prio_t[pick]) pick = i;
				end
			end
			if (now != pps_pkg::TIME_MAX) now = now + 1'b1;
			r = '0;
			r.idle = (pick < 0);
			if (pick >= 0) begin
				r.run_slot = pps_pkg::SLOT_W'(pick);
				left_t[pick] = left_t[pick] - 1'b1;
				if (left_t[pick] == 0) begin
					r.finished = 1'b1;
					if (done_cnt != pps_pkg::DONE_MAX) done_cnt = done_cnt + 1'b1;
					r.turnaround = now - arr_t[pick];
					r.waiting = (r.turnaround >= burst_t[pick]) ?
						r.turnaround - burst_t[pick] : '0;
					finishes++;
				end
			end else begin
				idles++;
			end
			r.end_time = now;
			r.all_done = (done_cnt >= n);
			if (r.all_done) all_done_seen++;
			slices_due.push_back(r);
		endfunction

		function void field_check(string name, logic [pps_pkg::TIME_W-1:0] e,
				logic [pps_pkg::TIME_W-1:0] a);
			if (e !== a) begin
				$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, e, a);
				errors++;
			end
		endfunction

		function void check_slice(logic [pps_pkg::M_TDATA_W-1:0] d,
				logic [pps_pkg::M_TUSER_W-1:0] u);
			slice_t e;
			if (slices_due.size() == 0) begin
				$display("%0t ns: unexpected slice, expected none, got tdata %h tuser %b",
					$time, d, u);
				errors++;
				return;
			end
			e = slices_due.pop_front();
			field_check("slice_end_time", e.end_time, d[15:0]);
			field_check("running_slot", pps_pkg::TIME_W'(e.run_slot),
				pps_pkg::TIME_W'(d[18:16]));
			field_check("turnaround", e.turnaround, d[34:19]);
			field_check("waiting", e.waiting, d[50:35]);
			field_check("all_done", pps_pkg::TIME_W'(e.all_done), pps_pkg::TIME_W'(d[51]));
			field_check("idle", pps_pkg::TIME_W'(e.idle), pps_pkg::TIME_W'(u[0]));
			field_check("finished", pps_pkg::TIME_W'(e.finished), pps_pkg::TIME_W'(u[1]));
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [pps_pkg::CFG_W-1:0]       cfg_data;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [pps_pkg::S_TDATA_W-1:0]   s_tdata;
	logic [pps_pkg::S_TUSER_W-1:0]   s_tuser;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [pps_pkg::M_TDATA_W-1:0]   m_tdata;
	logic [pps_pkg::M_TUSER_W-1:0]   m_tuser;

	sched_ledger ledger;
	bit          idling_on;
	bit          rx_stalls_on;
	int          sent;

	preemptive_priority_scheduler DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#6_000_000;
		$display("preemptive_priority_scheduler_tb NOT OK");
		$finish;
	end

	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_request(input logic cmd, input logic [pps_pkg::SLOT_W-1:0] s,
			input logic [pps_pkg::TIME_W-1:0] b, input logic [pps_pkg::TIME_W-1:0] a,
			input logic [pps_pkg::PRIO_W-1:0] p);
		int gap;
		gap = idling_on ? idle_span() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {5'b0, p, a, b, s};
		do @(posedge clk); while (!s_tready);
		ledger.take_request(cmd, s, b, a, p);
		sent++;
	endtask

	task automatic send_tick();
		send_request(pps_pkg::CMD_TICK, pps_pkg::SLOT_W'($urandom),
			pps_pkg::TIME_W'($urandom), pps_pkg::TIME_W'($urandom),
			pps_pkg::PRIO_W'($urandom));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (ledger.slices_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_proc_count(input logic [pps_pkg::CFG_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		ledger.set_proc_count(v);
	endtask

	task automatic run_job();
		int n;
		int total;
		int latest;
		int span;
		logic [pps_pkg::TIME_W-1:0] b;
		logic [pps_pkg::TIME_W-1:0] a;
		n = ledger.in_use();
		total = 0;
		latest = 0;
		idling_on = ($urandom_range(0, 4) != 0);
		rx_stalls_on = ($urandom_range(0, 4) != 0);
		for (int i = 0; i < n; i++) begin
			b = pps_pkg::TIME_W'($urandom_range(1, 6));
			a = pps_pkg::TIME_W'($urandom_range(0, 10));
			total += b;
			if (a > latest) latest = a;
			send_request(pps_pkg::CMD_LOAD, pps_pkg::SLOT_W'(i), b, a,
				pps_pkg::PRIO_W'($urandom_range(0, 1) ? $urandom_range(0, 3) :
					$urandom_range(0, 255)));
		end
		span = total + latest + $urandom_range(0, 3);
		if ($urandom_range(0, 9) == 0) span = span / 2;
		repeat (span) begin
			if ($urandom_range(0, 39) == 0)
				send_request(pps_pkg::CMD_LOAD, pps_pkg::SLOT_W'($urandom),
					pps_pkg::TIME_W'($urandom_range(1, 65535)),
					pps_pkg::TIME_W'($urandom), pps_pkg::PRIO_W'($urandom));
			send_tick();
		end
	endtask

	// result side: check, then decide ready for the next edge
	initial begin
		int stall;
		m_tready = 1'b0;
		stall = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) ledger.check_slice(m_tdata, m_tuser);
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
				if (rx_stalls_on && $urandom_range(0, 3) == 0) stall = idle_span() + 1;
			end
		end
	end

	initial begin
		int base;
		logic [pps_pkg::CFG_W-1:0] setting;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		idling_on = 1'b1;
		rx_stalls_on = 1'b1;
		sent = 0;
		ledger = new;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every slot gets loaded here, so no later tick reads an empty slot
		write_proc_count(4'd15);
		send_request(pps_pkg::CMD_LOAD, 3'd0, 16'd2, 16'd0, 8'd5);
		send_request(pps_pkg::CMD_LOAD, 3'd1, 16'd1, 16'd0, 8'd5);
		send_request(pps_pkg::CMD_LOAD, 3'd2, 16'd3, 16'd2, 8'd0);
		send_request(pps_pkg::CMD_LOAD, 3'd3, 16'd0, 16'd0, 8'd0);
		send_request(pps_pkg::CMD_LOAD, 3'd4, 16'hFFFF, 16'hFFFF, 8'hFF);
		send_request(pps_pkg::CMD_LOAD, 3'd5, 16'd1, 16'd1, 8'hFF);
		send_request(pps_pkg::CMD_LOAD, 3'd6, 16'd1, 16'd3, 8'd128);
		send_request(pps_pkg::CMD_LOAD, 3'd7, 16'd2, 16'd4, 8'd7);
		repeat (12) send_tick();
		drain();

		base = sent;
		while (sent - base < RANDOM_ITEMS) begin
			drain();
			case ($urandom_range(0, 5))
				0: setting = 4'd1;
				1: setting = 4'd8;
				2: setting = 4'd0;
				3: setting = 4'd15;
				default: setting = pps_pkg::CFG_W'($urandom_range(0, 15));
			endcase
			write_proc_count(setting);
			repeat ($urandom_range(1, 4)) begin
				run_job();
				if ($urandom_range(0, 5) == 0) drain();
			end
		end
		drain();

		ledger.errors += ledger.slices_due.size();
		$display("covered %0d loads and %0d ticks over %0d slot-count settings:",
			ledger.loads, ledger.ticks, ledger.settings);
		$display("  %0d idle slices, %0d completions, %0d slices with all slots done",
			ledger.idles, ledger.finishes, ledger.all_done_seen);
		if (ledger.errors == 0) begin
			$display("preemptive_priority_scheduler_tb OK");
		end else begin
			$display("preemptive_priority_scheduler_tb NOT OK");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/pps_pkg.sv
rtl/core/pps_slot_store.sv
rtl/core/preemptive_priority_scheduler.sv
rtl/core/pps_checker.sv
tb/preemptive_priority_scheduler_tb.sv
